@@ rtl/core/dcva_pkg.sv @@
`timescale 1ns / 1ps

package dcva_pkg;

    // window and field widths
    localparam int WINDOW_LENGTH = 30;
    localparam int POS_W         = $clog2(WINDOW_LENGTH);
    localparam int SAMPLE_W      = 10;
    localparam int GAIN_W        = 12;
    localparam int SUM_W         = 15;
    localparam int VOLTS_W       = 12;
    localparam int CHARGE_W      = 7;
    // one ring entry holds both samples
    localparam int ENTRY_W       = 2 * SAMPLE_W;

    // scaling: volts = sum * gain / DIVISOR, clamped to VOLTS_MAX
    localparam int PROD_W    = SUM_W + GAIN_W;
    localparam int DIV_W     = 15;
    localparam int RECIP_W   = 13;
    localparam int QE_W      = 13;
    localparam int RPROD_W   = PROD_W + RECIP_W;
    localparam int QD_W      = QE_W + DIV_W;

    localparam logic [DIV_W-1:0]   DIVISOR   = 15'd30609;
    // floor(2^PROD_W / DIVISOR): estimate is exact or one low
    localparam logic [RECIP_W-1:0] RECIP     = 13'd4384;
    localparam logic [VOLTS_W-1:0] VOLTS_MAX = 12'd4095;
    // smallest product whose quotient exceeds VOLTS_MAX
    localparam logic [PROD_W-1:0]  SAT_LIMIT = 27'd125374464;

    // register map, selected by paddr[2]
    localparam int ADDR_W = 3;
    localparam logic REG_MAINS_GAIN   = 1'b0;
    localparam logic REG_BATTERY_GAIN = 1'b1;
    localparam logic [GAIN_W-1:0] MAINS_GAIN_RST   = 12'd1600;
    localparam logic [GAIN_W-1:0] BATTERY_GAIN_RST = 12'd1500;

    // charge ladder, highest step first
    localparam int CHARGE_LEVELS = 10;
    localparam logic [VOLTS_W-1:0] CHARGE_STEP [CHARGE_LEVELS] = '{
        12'd1240, 12'd1235, 12'd1225, 12'd1215, 12'd1195,
        12'd1180, 12'd1165, 12'd1140, 12'd1120, 12'd1080
    };
    localparam logic [CHARGE_W-1:0] CHARGE_PCT [CHARGE_LEVELS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60,
        7'd50, 7'd40, 7'd30, 7'd20, 7'd10
    };

    // load strobes of the scaling stages
    typedef struct packed {
        logic ld3;
        logic ld4;
        logic ld5;
        logic ld6;
    } stage_en_t;

    function automatic logic [CHARGE_W-1:0] charge_of(input logic [VOLTS_W-1:0] volts);
        logic [CHARGE_W-1:0] pct;
        pct = '0;
        for (int i = CHARGE_LEVELS - 1; i >= 0; i--) begin
            if (volts > CHARGE_STEP[i]) begin
                pct = CHARGE_PCT[i];
            end
        end
        return pct;
    endfunction

endpackage

@@ rtl/core/dcva_scale.sv @@
`timescale 1ns / 1ps

module dcva_scale (
    input  logic                              aclk,
    input  dcva_pkg::stage_en_t               stage_en,
    input  logic [dcva_pkg::SUM_W-1:0]        sum,
    input  logic [dcva_pkg::GAIN_W-1:0]       gain,
    output logic [dcva_pkg::VOLTS_W-1:0]      volts
);

    logic [dcva_pkg::PROD_W-1:0]  prod_reg;
    logic [dcva_pkg::PROD_W-1:0]  p4_reg;
    logic [dcva_pkg::PROD_W-1:0]  p5_reg;
    logic                         sat4_reg;
    logic                         sat5_reg;
    logic [dcva_pkg::QE_W-1:0]    qe4_reg;
    logic [dcva_pkg::QE_W-1:0]    qe5_reg;
    logic [dcva_pkg::QD_W-1:0]    qd_reg;
    logic [dcva_pkg::VOLTS_W-1:0] volts_reg;

    logic [dcva_pkg::PROD_W-1:0]  prod_next;
    logic [dcva_pkg::RPROD_W-1:0] rprod;
    logic [dcva_pkg::QD_W-1:0]    qd_next;
    logic [dcva_pkg::QD_W-1:0]    diff;
    logic [dcva_pkg::QE_W-1:0]    q;
    logic [dcva_pkg::VOLTS_W-1:0] volts_next;

    assign prod_next = dcva_pkg::PROD_W'(sum) * dcva_pkg::PROD_W'(gain);
    // quotient estimate by reciprocal
    assign rprod     = dcva_pkg::RPROD_W'(prod_reg) * dcva_pkg::RPROD_W'(dcva_pkg::RECIP);
    assign qd_next   = dcva_pkg::QD_W'(qe4_reg) * dcva_pkg::QD_W'(dcva_pkg::DIVISOR);
    // remainder stays below twice the divisor: one correction step
    assign diff      = dcva_pkg::QD_W'(p5_reg) - qd_reg;
    assign q         = qe5_reg
                     + dcva_pkg::QE_W'(diff >= dcva_pkg::QD_W'(dcva_pkg::DIVISOR));
    assign volts_next = sat5_reg ? dcva_pkg::VOLTS_MAX : q[dcva_pkg::VOLTS_W-1:0];

    always_ff @(posedge aclk) begin
        if (stage_en.ld3) begin
            prod_reg <= prod_next;
        end
        if (stage_en.ld4) begin
            p4_reg   <= prod_reg;
            sat4_reg <= (prod_reg >= dcva_pkg::SAT_LIMIT);
            qe4_reg  <= rprod[dcva_pkg::RPROD_W-1:dcva_pkg::PROD_W];
        end
        if (stage_en.ld5) begin
            p5_reg   <= p4_reg;
            sat5_reg <= sat4_reg;
            qe5_reg  <= qe4_reg;
            qd_reg   <= qd_next;
        end
        if (stage_en.ld6) begin
            volts_reg <= volts_next;
        end
    end

    assign volts = volts_reg;

endmodule

@@ rtl/core/dual_channel_voltage_averager.sv @@
`timescale 1ns / 1ps

// dual-channel sliding-window voltage averager
//
// input stream: one transfer carries a mains and a battery converter sample.
// both go into 30-entry rings at a shared write position; running sums of
// the rings are scaled by the gain registers, divided by 30609 and clamped
// to 4095 (hundredths of a volt). the battery voltage also picks a charge
// estimate from a ten-step ladder. every input transfer yields one output
// transfer carrying mains volts, battery volts and charge percent.
//
// throughput: one transfer per cycle while m_axis_tready stays high. the ring is
// one 20-bit memory; the old entry is read in the accept cycle and written back
// when the item enters the sums stage, and consecutive items never touch the same entry.
// pipeline: an input transfer passes ring read, sum update, multiply, reciprocal
// estimate, divisor product, correction and ladder before m_axis_tvalid rises.
//
// reset: rings read as zero (one valid flag per entry), position and sums
// clear, gains return to 1600 and 1500. when the receiver stalls, the
// pipeline fills its empty stages before s_axis_tready drops; no data lost.
// config port: mains_gain at 0x0, battery_gain at 0x4, write while idle.

module dual_channel_voltage_averager (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] mains_sample, [19:10] battery_sample, [23:20] zero
    input  logic [23:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] mains_volts, [23:12] battery_volts, [30:24] charge_percent, [31] zero
    output logic [31:0] m_axis_tdata,

    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dcva_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // configuration registers
    logic [dcva_pkg::GAIN_W-1:0] mains_gain_reg;
    logic [dcva_pkg::GAIN_W-1:0] battery_gain_reg;
    logic                        cfg_wr;

    // ring memory: battery sample in the upper half
    logic [dcva_pkg::ENTRY_W-1:0] ring_mem [dcva_pkg::WINDOW_LENGTH];
    logic [dcva_pkg::ENTRY_W-1:0] rd_reg;
    logic [dcva_pkg::WINDOW_LENGTH-1:0] entry_valid_reg;

    // write position
    logic [dcva_pkg::POS_W-1:0] pos_reg;
    logic [dcva_pkg::POS_W-1:0] pos_next;

    // stage valids: 1 = ring read, 2 = sums, 3..6 = scaling, out = result
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_o;
    logic ld1, ld2, ld3, ld4, ld5, ld6, ldo;

    // stage 1 payload
    logic [dcva_pkg::SAMPLE_W-1:0] m1_reg;
    logic [dcva_pkg::SAMPLE_W-1:0] b1_reg;
    logic [dcva_pkg::POS_W-1:0]    pos1_reg;
    logic                          old_valid1_reg;

    // running sums
    logic [dcva_pkg::SUM_W-1:0] mains_sum_reg;
    logic [dcva_pkg::SUM_W-1:0] battery_sum_reg;
    logic [dcva_pkg::SUM_W-1:0] mains_sum_next;
    logic [dcva_pkg::SUM_W-1:0] battery_sum_next;
    logic [dcva_pkg::SAMPLE_W-1:0] old_m;
    logic [dcva_pkg::SAMPLE_W-1:0] old_b;

    dcva_pkg::stage_en_t stage_en;
    logic [dcva_pkg::VOLTS_W-1:0] mains_volts6;
    logic [dcva_pkg::VOLTS_W-1:0] battery_volts6;

    // output register
    logic [dcva_pkg::VOLTS_W-1:0]  mains_volts_reg;
    logic [dcva_pkg::VOLTS_W-1:0]  battery_volts_reg;
    logic [dcva_pkg::CHARGE_W-1:0] charge_reg;

    // ---------------------------------------------------------------
    // config port
    // ---------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mains_gain_reg   <= dcva_pkg::MAINS_GAIN_RST;
            battery_gain_reg <= dcva_pkg::BATTERY_GAIN_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                dcva_pkg::REG_MAINS_GAIN:   mains_gain_reg   <= pwdata[dcva_pkg::GAIN_W-1:0];
                dcva_pkg::REG_BATTERY_GAIN: battery_gain_reg <= pwdata[dcva_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dcva_pkg::REG_MAINS_GAIN:   prdata = 32'(mains_gain_reg);
            dcva_pkg::REG_BATTERY_GAIN: prdata = 32'(battery_gain_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline flow control: a stage takes new data when empty or moving on
    // ---------------------------------------------------------------
    assign rdy_o = !vo_reg || m_axis_tready;
    assign rdy6  = !v6_reg || rdy_o;
    assign rdy5  = !v5_reg || rdy6;
    assign rdy4  = !v4_reg || rdy5;
    assign rdy3  = !v3_reg || rdy4;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;

    assign s_axis_tready = rdy1;
    assign ld1 = s_axis_tvalid & rdy1;
    assign ld2 = v1_reg & rdy2;
    assign ld3 = v2_reg & rdy3;
    assign ld4 = v3_reg & rdy4;
    assign ld5 = v4_reg & rdy5;
    assign ld6 = v5_reg & rdy6;
    assign ldo = v6_reg & rdy_o;

    assign stage_en = '{ld3: ld3, ld4: ld4, ld5: ld5, ld6: ld6};

    assign pos_next = (pos_reg == dcva_pkg::POS_W'(dcva_pkg::WINDOW_LENGTH - 1))
                    ? '0 : pos_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            v6_reg          <= 1'b0;
            vo_reg          <= 1'b0;
            pos_reg         <= '0;
            entry_valid_reg <= '0;
            mains_sum_reg   <= '0;
            battery_sum_reg <= '0;
        end else begin
            v1_reg <= ld1 | (v1_reg & !rdy2);
            v2_reg <= ld2 | (v2_reg & !rdy3);
            v3_reg <= ld3 | (v3_reg & !rdy4);
            v4_reg <= ld4 | (v4_reg & !rdy5);
            v5_reg <= ld5 | (v5_reg & !rdy6);
            v6_reg <= ld6 | (v6_reg & !rdy_o);
            vo_reg <= ldo | (vo_reg & !m_axis_tready);
            if (ld1) begin
                pos_reg <= pos_next;
            end
            if (ld2) begin
                entry_valid_reg[pos1_reg] <= 1'b1;
                mains_sum_reg             <= mains_sum_next;
                battery_sum_reg           <= battery_sum_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // ring read in the accept cycle, write-back one stage later
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ld1) begin
            rd_reg         <= ring_mem[pos_reg];
            old_valid1_reg <= entry_valid_reg[pos_reg];
            m1_reg         <= s_axis_tdata[dcva_pkg::SAMPLE_W-1:0];
            b1_reg         <= s_axis_tdata[dcva_pkg::ENTRY_W-1:dcva_pkg::SAMPLE_W];
            pos1_reg       <= pos_reg;
        end
        if (ld2) begin
            ring_mem[pos1_reg] <= {b1_reg, m1_reg};
        end
    end

    // never-written entries count as zero
    assign old_m = old_valid1_reg ? rd_reg[dcva_pkg::SAMPLE_W-1:0] : '0;
    assign old_b = old_valid1_reg ? rd_reg[dcva_pkg::ENTRY_W-1:dcva_pkg::SAMPLE_W] : '0;

    assign mains_sum_next   = mains_sum_reg - dcva_pkg::SUM_W'(old_m)
                            + dcva_pkg::SUM_W'(m1_reg);
    assign battery_sum_next = battery_sum_reg - dcva_pkg::SUM_W'(old_b)
                            + dcva_pkg::SUM_W'(b1_reg);

    // ---------------------------------------------------------------
    // scaling, one unit per channel
    // ---------------------------------------------------------------
    dcva_scale u_mains_scale (
        .aclk     (aclk),
        .stage_en (stage_en),
        .sum      (mains_sum_reg),
        .gain     (mains_gain_reg),
        .volts    (mains_volts6)
    );

    dcva_scale u_battery_scale (
        .aclk     (aclk),
        .stage_en (stage_en),
        .sum      (battery_sum_reg),
        .gain     (battery_gain_reg),
        .volts    (battery_volts6)
    );

    // ---------------------------------------------------------------
    // charge ladder and output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ldo) begin
            mains_volts_reg   <= mains_volts6;
            battery_volts_reg <= battery_volts6;
            charge_reg        <= dcva_pkg::charge_of(battery_volts6);
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {1'b0, charge_reg, battery_volts_reg, mains_volts_reg};

endmodule

@@ dv/dcva_reading_checker.sv @@
`timescale 1ns / 1ps

module dcva_reading_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [9:0] mains_sample, [19:10] battery_sample, [23:20] zero
    input  logic [23:0] s_axis_tdata,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] mains_volts, [23:12] battery_volts, [30:24] charge_percent, [31] zero
    input  logic [31:0] m_axis_tdata,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dcva_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,

    output int          fail_count,
    output int          pending,
    output int          result_count,
    output int          sat_count,
    output logic [10:0] charge_seen
);

    localparam longint unsigned VOLT_DIVISOR = 30609;
    localparam longint unsigned VOLT_CAP     = 4095;
    localparam int LADDER_STEPS = 10;
    localparam logic [dcva_pkg::VOLTS_W-1:0] LADDER [LADDER_STEPS] = '{
        12'd1240, 12'd1235, 12'd1225, 12'd1215, 12'd1195,
        12'd1180, 12'd1165, 12'd1140, 12'd1120, 12'd1080
    };

    typedef struct packed {
        logic [dcva_pkg::VOLTS_W-1:0]  mains_volts;
        logic [dcva_pkg::VOLTS_W-1:0]  battery_volts;
        logic [dcva_pkg::CHARGE_W-1:0] charge_percent;
    } reading_t;

    reading_t readings_due[$];

    logic [dcva_pkg::SAMPLE_W-1:0] mains_hist [dcva_pkg::WINDOW_LENGTH];
    logic [dcva_pkg::SAMPLE_W-1:0] battery_hist [dcva_pkg::WINDOW_LENGTH];
    logic [dcva_pkg::POS_W-1:0]    slot;
    logic [dcva_pkg::SUM_W-1:0]    mains_total;
    logic [dcva_pkg::SUM_W-1:0]    battery_total;
    logic [dcva_pkg::GAIN_W-1:0]   mains_gain;
    logic [dcva_pkg::GAIN_W-1:0]   battery_gain;
    int                            fails;
    int                            results;
    int                            saturated;
    logic [10:0]                   levels;

    function automatic logic [dcva_pkg::VOLTS_W-1:0] scaled_volts(
        input logic [dcva_pkg::SUM_W-1:0]  total,
        input logic [dcva_pkg::GAIN_W-1:0] gain
    );
        longint unsigned a;
        longint unsigned b;
        longint unsigned quotient;
        a = 64'(total);
        b = 64'(gain);
        quotient = (a * b) / VOLT_DIVISOR;
        if (quotient > VOLT_CAP) begin
            quotient = VOLT_CAP;
        end
        return quotient[dcva_pkg::VOLTS_W-1:0];
    endfunction

    // first step passed from the top wins
    function automatic logic [dcva_pkg::CHARGE_W-1:0] charge_from(
        input logic [dcva_pkg::VOLTS_W-1:0] volts
    );
        logic [dcva_pkg::CHARGE_W-1:0] pct;
        pct = '0;
        for (int i = LADDER_STEPS - 1; i >= 0; i--) begin
            if (volts > LADDER[i]) begin
                pct = dcva_pkg::CHARGE_W'(100 - 10 * i);
            end
        end
        return pct;
    endfunction

    always @(posedge aclk) begin : track
        reading_t                      want;
        logic [dcva_pkg::SAMPLE_W-1:0] m_in;
        logic [dcva_pkg::SAMPLE_W-1:0] b_in;
        if (!aresetn) begin
            for (int i = 0; i < dcva_pkg::WINDOW_LENGTH; i++) begin
                mains_hist[i]   = '0;
                battery_hist[i] = '0;
            end
            slot          = '0;
            mains_total   = '0;
            battery_total = '0;
            mains_gain    = dcva_pkg::MAINS_GAIN_RST;
            battery_gain  = dcva_pkg::BATTERY_GAIN_RST;
            readings_due.delete();
            fails     = 0;
            results   = 0;
            saturated = 0;
            levels    = '0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {dcva_pkg::REG_MAINS_GAIN, 2'b00}) begin
                    mains_gain = pwdata[dcva_pkg::GAIN_W-1:0];
                end else if (paddr == {dcva_pkg::REG_BATTERY_GAIN, 2'b00}) begin
                    battery_gain = pwdata[dcva_pkg::GAIN_W-1:0];
                end
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (readings_due.size() == 0) begin
                    $error("output transfer with no reading due: data %h", m_axis_tdata);
                    fails++;
                end else begin
                    want = readings_due.pop_front();
                    if (m_axis_tdata[11:0] !== want.mains_volts) begin
                        $error("mains_volts: expected %0d, actual %0d",
                               want.mains_volts, m_axis_tdata[11:0]);
                        fails++;
                    end
                    if (m_axis_tdata[23:12] !== want.battery_volts) begin
                        $error("battery_volts: expected %0d, actual %0d",
                               want.battery_volts, m_axis_tdata[23:12]);
                        fails++;
                    end
                    if (m_axis_tdata[30:24] !== want.charge_percent) begin
                        $error("charge_percent: expected %0d, actual %0d",
                               want.charge_percent, m_axis_tdata[30:24]);
                        fails++;
                    end
                    results++;
                    if (want.mains_volts == dcva_pkg::VOLTS_MAX
                            || want.battery_volts == dcva_pkg::VOLTS_MAX) begin
                        saturated++;
                    end
                    levels[want.charge_percent / 10] = 1'b1;
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                m_in = s_axis_tdata[9:0];
                b_in = s_axis_tdata[19:10];
                mains_total   = mains_total - dcva_pkg::SUM_W'(mains_hist[slot])
                              + dcva_pkg::SUM_W'(m_in);
                battery_total = battery_total - dcva_pkg::SUM_W'(battery_hist[slot])
                              + dcva_pkg::SUM_W'(b_in);
                mains_hist[slot]   = m_in;
                battery_hist[slot] = b_in;
                slot = (slot == dcva_pkg::POS_W'(dcva_pkg::WINDOW_LENGTH - 1))
                     ? '0 : slot + 1'b1;
                want.mains_volts    = scaled_volts(mains_total, mains_gain);
                want.battery_volts  = scaled_volts(battery_total, battery_gain);
                want.charge_percent = charge_from(want.battery_volts);
                readings_due.push_back(want);
            end
        end
        fail_count   <= fails;
        pending      <= readings_due.size();
        result_count <= results;
        sat_count    <= saturated;
        charge_seen  <= levels;
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // long receiver hold-off, enough to back the pipeline up into the input
    localparam int HOLD_CYCLES  = 120;
    // settle time after the last reading
    localparam int SETTLE       = 20;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 8;

    logic        aclk;
    logic        aresetn;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [9:0] mains_sample, [19:10] battery_sample, [23:20] zero
    logic [23:0] s_axis_tdata;

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [11:0] mains_volts, [23:12] battery_volts, [30:24] charge_percent, [31] zero
    logic [31:0] m_axis_tdata;

    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [dcva_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    int          fail_count;
    int          pending;
    int          result_count;
    int          sat_count;
    logic [10:0] charge_seen;

    // stimulus knobs; sink_calm and hold_sink are shared with the receiver process
    bit source_calm;
    bit sink_calm;
    bit hold_sink;
    int battery_gain_now;
    int gain_settings;

    dual_channel_voltage_averager dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // watches both streams and the config port, predicts every reading
    dcva_reading_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .result_count  (result_count),
        .sat_count     (sat_count),
        .charge_seen   (charge_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("dual_channel_voltage_averager test failed");
        $finish;
    end

    // receiver: random stall before each transfer, plus one long hold-off on request
    initial begin : sink
        int waits;
        m_axis_tready = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            if (hold_sink) begin
                hold_sink = 1'b0;
                @(negedge aclk);
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            waits = sink_calm ? 0 : $urandom_range(0, 4);
            repeat (waits) begin
                @(negedge aclk);
                m_axis_tready <= 1'b0;
            end
            @(negedge aclk);
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    function automatic logic [dcva_pkg::SAMPLE_W-1:0] clip_sample(input int value);
        if (value < 0) begin
            return '0;
        end else if (value > 1023) begin
            return 10'd1023;
        end
        return dcva_pkg::SAMPLE_W'(value);
    endfunction

    // one input transfer, after a random gap with junk on the idle bus
    task automatic send_reading(input logic [dcva_pkg::SAMPLE_W-1:0] mains,
                                input logic [dcva_pkg::SAMPLE_W-1:0] battery);
        int gap;
        gap = source_calm ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 24'($urandom());
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, battery, mains};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // stop sending and wait until every predicted reading has come out
    task automatic drain;
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle; upper data bits carry junk
    task automatic write_gain(input logic reg_sel,
                              input logic [dcva_pkg::GAIN_W-1:0] value);
        logic [19:0] junk;
        junk = 20'($urandom());
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {junk, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_gains(input logic [dcva_pkg::GAIN_W-1:0] mains_g,
                             input logic [dcva_pkg::GAIN_W-1:0] battery_g);
        drain();
        write_gain(dcva_pkg::REG_MAINS_GAIN, mains_g);
        write_gain(dcva_pkg::REG_BATTERY_GAIN, battery_g);
        battery_gain_now = int'(battery_g);
        gain_settings++;
    endtask

    // random readings in segments of one style each:
    // battery hovering around the charge ladder, near full scale, near zero, or noise
    task automatic run_phase(input int item_total, input bit with_hold);
        int done;
        int seg_len;
        int style;
        int center;
        int spread;
        int mains_base;
        logic [dcva_pkg::SAMPLE_W-1:0] m_s;
        logic [dcva_pkg::SAMPLE_W-1:0] b_s;
        done = 0;
        while (done < item_total) begin
            seg_len     = $urandom_range(10, 60);
            style       = $urandom_range(0, 19);
            source_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            if (with_hold && done == 0) begin
                hold_sink = 1'b1;
            end
            mains_base = $urandom_range(0, 1023);
            // sample level whose full window lands in the middle of the ladder
            center = (battery_gain_now == 0) ? 512 : 1183548 / battery_gain_now;
            if (center > 1023) begin
                center = 1023;
            end
            spread = center / 10 + 2;
            for (int k = 0; k < seg_len && done < item_total; k++) begin
                if (style < 10) begin
                    b_s = clip_sample(center + int'($urandom_range(0, 2 * spread)) - spread);
                    m_s = clip_sample(mains_base + int'($urandom_range(0, 32)) - 16);
                end else if (style < 13) begin
                    // full-scale surge, near the clamp at high gain once the window fills
                    b_s = dcva_pkg::SAMPLE_W'($urandom_range(1000, 1023));
                    m_s = dcva_pkg::SAMPLE_W'($urandom_range(1000, 1023));
                end else if (style < 16) begin
                    b_s = dcva_pkg::SAMPLE_W'($urandom_range(0, 15));
                    m_s = dcva_pkg::SAMPLE_W'($urandom_range(0, 15));
                end else begin
                    b_s = dcva_pkg::SAMPLE_W'($urandom());
                    m_s = dcva_pkg::SAMPLE_W'($urandom());
                end
                send_reading(m_s, b_s);
                done++;
            end
        end
    endtask

    initial begin : stimulus
        logic [dcva_pkg::GAIN_W-1:0] mg;
        logic [dcva_pkg::GAIN_W-1:0] bg;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        source_calm   = 1'b0;
        sink_calm     = 1'b0;
        hold_sink     = 1'b0;
        battery_gain_now = int'(dcva_pkg::BATTERY_GAIN_RST);
        gain_settings = 1;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes and alternating bits while the window is still filling
        send_reading(10'd0, 10'd0);
        send_reading(10'd1023, 10'd1023);
        send_reading(10'd1023, 10'd0);
        send_reading(10'd0, 10'd1023);
        send_reading(10'h2AA, 10'h155);
        send_reading(10'h155, 10'h2AA);
        send_reading(10'd1, 10'd1);
        send_reading(10'd512, 10'd512);

        // reset gains first; the long receiver hold-off falls in this phase
        run_phase(PHASE_ITEMS, 1'b1);

        for (int p = 1; p < PHASES; p++) begin
            case (p)
                1: begin mg = 12'd4095; bg = 12'd4095; end
                2: begin mg = 12'd0;    bg = 12'd0;    end
                3: begin mg = 12'd1;    bg = 12'd4095; end
                4: begin mg = 12'd4095; bg = 12'd1;    end
                7: begin mg = dcva_pkg::MAINS_GAIN_RST; bg = dcva_pkg::BATTERY_GAIN_RST; end
                default: begin
                    mg = dcva_pkg::GAIN_W'($urandom());
                    bg = dcva_pkg::GAIN_W'($urandom_range(1200, 4095));
                end
            endcase
            set_gains(mg, bg);
            run_phase(PHASE_ITEMS, 1'b0);
        end

        drain();
        $display("checked %0d readings over %0d gain settings, %0d at the 4095 clamp",
                 result_count, gain_settings, sat_count);
        $display("charge levels seen (bit n = n*10 percent): %b", charge_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("dual_channel_voltage_averager test passed");
        end else begin
            $display("dual_channel_voltage_averager test failed");
        end
        $finish;
    end

endmodule
